>>> rtl/ufe_pkg.sv
// Shared types, character codes and helper functions of the form field extractor.
package ufe_pkg;

  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef enum logic [1:0] {
    REG_KEY_BYTES        = 2'd0,
    REG_KEY_LENGTH       = 2'd1,
    REG_MAX_VALUE_LENGTH = 2'd2
  } reg_index_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_TOO_LONG  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    EMIT_DECODE    = 2'd0,
    EMIT_EMPTY     = 2'd1,
    EMIT_NOT_FOUND = 2'd2,
    EMIT_TOO_LONG  = 2'd3
  } emit_kind_e;

  typedef enum logic [3:0] {
    PH_MATCH = 4'b0001,
    PH_VALUE = 4'b0010,
    PH_SKIP  = 4'b0100,
    PH_DONE  = 4'b1000
  } scan_phase_e;

  typedef enum logic [5:0] {
    E_IDLE  = 6'b000001,
    E_FETCH = 6'b000010,
    E_CHAR  = 6'b000100,
    E_HI    = 6'b001000,
    E_LO    = 6'b010000,
    E_PUT   = 6'b100000
  } emit_state_e;

  typedef struct packed {
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [6:0]  max_value_length;
  } cfg_t;

  typedef struct packed {
    logic       start;
    emit_kind_e kind;
  } emit_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    status_e    status;
    logic       last;
  } result_t;

  // Returns {valid, nibble} for an ASCII hex digit.
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

>>> rtl/ufe_cfg_regs.sv
// APB configuration registers of the form field extractor.
module ufe_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [4:0]         paddr_i,
  input  logic [63:0]        pwdata_i,
  output logic [63:0]        prdata_o,
  output logic               pready_o,
  output ufe_pkg::cfg_t      cfg_o
);

  ufe_pkg::cfg_t       cfg_q, cfg_d;
  ufe_pkg::reg_index_e sel;
  logic                wr_en;

  assign sel      = ufe_pkg::reg_index_e'(paddr_i[4:3]);
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  always_comb begin
    cfg_d    = cfg_q;
    prdata_o = '0;
    unique case (sel)
      ufe_pkg::REG_KEY_BYTES: begin
        prdata_o = cfg_q.key_bytes;
        if (wr_en) cfg_d.key_bytes = pwdata_i;
      end
      ufe_pkg::REG_KEY_LENGTH: begin
        prdata_o = 64'(cfg_q.key_length);
        if (wr_en) cfg_d.key_length = pwdata_i[3:0];
      end
      ufe_pkg::REG_MAX_VALUE_LENGTH: begin
        prdata_o = 64'(cfg_q.max_value_length);
        if (wr_en) cfg_d.max_value_length = pwdata_i[6:0];
      end
      default: begin
        prdata_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_bytes        <= 64'd0;
      cfg_q.key_length       <= 4'd1;
      cfg_q.max_value_length <= 7'd32;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/ufe_value_ram.sv
// Single-port-write, registered-read buffer for the raw value bytes.
module ufe_value_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ufe_emitter.sv
// Reads the buffered value back, URL-decodes it and drives the result register.
module ufe_emitter #(
  parameter int CNT_W = 7,
  parameter int AW    = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ufe_pkg::emit_req_t req_i,
  input  logic [CNT_W-1:0]   n_i,
  output logic               busy_o,
  output logic [AW-1:0]      raddr_o,
  input  logic [7:0]         rdata_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [7:0]         value_byte_o,
  output logic               byte_present_o,
  output logic [1:0]         status_o,
  output logic               final_result_o
);

  ufe_pkg::emit_state_e state_q, state_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     n_q, n_d;
  logic [3:0]           hi_q, hi_d;
  ufe_pkg::result_t     res_q, res_d;
  ufe_pkg::result_t     out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic [4:0]           hex;
  logic [CNT_W:0]       idx_ext;
  logic [CNT_W:0]       n_ext;
  logic [CNT_W:0]       step_sum;
  logic [CNT_W:0]       rd_sum;
  logic [1:0]           step;
  logic [1:0]           rd_off;
  logic                 advance;
  logic                 out_free;

  assign hex      = ufe_pkg::hex_decode(rdata_i);
  assign idx_ext  = {1'b0, idx_q};
  assign n_ext    = {1'b0, n_q};
  assign step_sum = idx_ext + (CNT_W+1)'(step);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (state_q)
      ufe_pkg::E_CHAR: rd_off = 2'd1;
      ufe_pkg::E_HI:   rd_off = 2'd2;
      default:         rd_off = 2'd0;
    endcase
  end

  assign rd_sum  = idx_ext + (CNT_W+1)'(rd_off);
  assign raddr_o = AW'(rd_sum);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    n_d         = n_q;
    hi_d        = hi_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    step        = 2'd1;
    advance     = 1'b0;

    unique case (state_q)
      ufe_pkg::E_IDLE: begin
        if (req_i.start) begin
          res_d = '{data: 8'h00, present: 1'b0, status: ufe_pkg::STATUS_OK, last: 1'b1};
          unique case (req_i.kind)
            ufe_pkg::EMIT_DECODE: begin
              idx_d   = '0;
              n_d     = n_i;
              state_d = ufe_pkg::E_FETCH;
            end
            ufe_pkg::EMIT_EMPTY: begin
              state_d = ufe_pkg::E_PUT;
            end
            ufe_pkg::EMIT_NOT_FOUND: begin
              res_d.status = ufe_pkg::STATUS_NOT_FOUND;
              state_d      = ufe_pkg::E_PUT;
            end
            ufe_pkg::EMIT_TOO_LONG: begin
              res_d.status = ufe_pkg::STATUS_TOO_LONG;
              state_d      = ufe_pkg::E_PUT;
            end
            default: begin
              state_d = ufe_pkg::E_IDLE;
            end
          endcase
        end
      end
      ufe_pkg::E_FETCH: begin
        state_d = ufe_pkg::E_CHAR;
      end
      ufe_pkg::E_CHAR: begin
        if (rdata_i == ufe_pkg::CHAR_PCT && (idx_ext + (CNT_W+1)'(2)) < n_ext) begin
          state_d = ufe_pkg::E_HI;
        end else begin
          res_d.data = (rdata_i == ufe_pkg::CHAR_PLUS) ? ufe_pkg::CHAR_SPACE : rdata_i;
          advance    = 1'b1;
        end
      end
      ufe_pkg::E_HI: begin
        if (hex[4]) begin
          hi_d    = hex[3:0];
          state_d = ufe_pkg::E_LO;
        end else begin
          res_d.data = ufe_pkg::CHAR_PCT;
          advance    = 1'b1;
        end
      end
      ufe_pkg::E_LO: begin
        if (hex[4]) begin
          res_d.data = {hi_q, hex[3:0]};
          step       = 2'd3;
        end else begin
          res_d.data = ufe_pkg::CHAR_PCT;
        end
        advance = 1'b1;
      end
      ufe_pkg::E_PUT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = res_q.last ? ufe_pkg::E_IDLE : ufe_pkg::E_FETCH;
        end
      end
      default: begin
        state_d = ufe_pkg::E_IDLE;
      end
    endcase

    if (advance) begin
      idx_d         = CNT_W'(step_sum);
      res_d.present = 1'b1;
      res_d.status  = ufe_pkg::STATUS_OK;
      res_d.last    = (step_sum >= n_ext);
      state_d       = ufe_pkg::E_PUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ufe_pkg::E_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    n_q   <= n_d;
    hi_q  <= hi_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign busy_o         = (state_q != ufe_pkg::E_IDLE);
  assign out_valid_o    = out_valid_q;
  assign value_byte_o   = out_q.data;
  assign byte_present_o = out_q.present;
  assign status_o       = out_q.status;
  assign final_result_o = out_q.last;

endmodule

>>> rtl/urlencoded_form_field_extract.sv
// Top level of the URL-encoded form field extractor: key scan, value buffer and decoder.
// Bytes stream in at one per cycle while no result is being emitted. Emission stalls input:
// a result byte passes the fetch, character and put states, a valid percent escape also the high
// and low nibble states; the value buffer read is registered and put waits on a stalled output.
// A status-only result goes straight to put. Reset clears the scan state, the decoder sequencer
// and the output valid flag and loads the register defaults; the buffer keeps its contents.
module urlencoded_form_field_extract #(
  parameter int VALUE_DEPTH = 64,
  parameter int KEY_MAX     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  body_byte_i,
  input  logic        body_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  value_byte_o,
  output logic        byte_present_o,
  output logic [1:0]  status_o,
  output logic        final_result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int LIM_MAX = (VALUE_DEPTH < 64) ? VALUE_DEPTH : 64;
  localparam int CNT_W   = $clog2(LIM_MAX + 2);
  localparam int AW      = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;
  localparam int PW      = $clog2(KEY_MAX + 1);

  ufe_pkg::cfg_t        cfg;
  ufe_pkg::scan_phase_e phase_q, phase_d;
  logic [PW-1:0]        pos_q, pos_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [PW-1:0]        klen;
  logic [6:0]           lim;
  logic [7:0]           key_char;
  logic                 in_acc;
  logic                 is_zero;
  logic                 body_done;
  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  logic [7:0]           ram_rdata;
  ufe_pkg::emit_req_t   emit_req;
  logic [CNT_W-1:0]     emit_n;
  logic                 emit_value;
  logic                 emit_busy;

  ufe_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  assign klen = (cfg.key_length > KEY_MAX) ? PW'(KEY_MAX) : PW'(cfg.key_length);
  assign lim  = (cfg.max_value_length > 7'(LIM_MAX)) ? 7'(LIM_MAX) : cfg.max_value_length;

  assign key_char  = cfg.key_bytes[8*3'(pos_q) +: 8];
  assign in_acc    = in_valid_i && !in_stall_o;
  assign is_zero   = (body_byte_i == ufe_pkg::CHAR_NUL);
  assign body_done = body_end_i || is_zero;

  always_comb begin
    phase_d        = phase_q;
    pos_d          = pos_q;
    cnt_d          = cnt_q;
    ram_we         = 1'b0;
    emit_req.start = 1'b0;
    emit_req.kind  = ufe_pkg::EMIT_DECODE;
    emit_n         = cnt_q;
    emit_value     = 1'b0;

    if (in_acc) begin
      if (!is_zero) begin
        unique case (phase_q)
          ufe_pkg::PH_MATCH: begin
            if (body_byte_i == ufe_pkg::CHAR_AMP) begin
              pos_d = '0;
            end else if (pos_q < klen) begin
              if (body_byte_i == key_char) pos_d = pos_q + PW'(1);
              else phase_d = ufe_pkg::PH_SKIP;
            end else if (body_byte_i == ufe_pkg::CHAR_EQ) begin
              phase_d = ufe_pkg::PH_VALUE;
              cnt_d   = '0;
            end else begin
              phase_d = ufe_pkg::PH_SKIP;
            end
          end
          ufe_pkg::PH_VALUE: begin
            if (body_byte_i == ufe_pkg::CHAR_AMP) begin
              phase_d    = ufe_pkg::PH_DONE;
              emit_value = 1'b1;
            end else begin
              ram_we = (32'(cnt_q) < VALUE_DEPTH);
              if (8'(cnt_q) <= 8'(lim)) cnt_d = cnt_q + CNT_W'(1);
            end
          end
          ufe_pkg::PH_SKIP: begin
            if (body_byte_i == ufe_pkg::CHAR_AMP) begin
              phase_d = ufe_pkg::PH_MATCH;
              pos_d   = '0;
            end
          end
          ufe_pkg::PH_DONE: begin
            phase_d = ufe_pkg::PH_DONE;
          end
          default: begin
            phase_d = ufe_pkg::PH_MATCH;
          end
        endcase
      end

      if (body_done) begin
        if (phase_d == ufe_pkg::PH_VALUE) begin
          emit_value = 1'b1;
          emit_n     = cnt_d;
        end else if (phase_d != ufe_pkg::PH_DONE) begin
          emit_req.start = 1'b1;
          emit_req.kind  = ufe_pkg::EMIT_NOT_FOUND;
        end
        phase_d = ufe_pkg::PH_MATCH;
        pos_d   = '0;
      end
    end

    if (emit_value) begin
      emit_req.start = 1'b1;
      if (8'(emit_n) > 8'(lim)) emit_req.kind = ufe_pkg::EMIT_TOO_LONG;
      else if (emit_n == '0) emit_req.kind = ufe_pkg::EMIT_EMPTY;
      else emit_req.kind = ufe_pkg::EMIT_DECODE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ufe_pkg::PH_MATCH;
      pos_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
    end
  end

  ufe_value_ram #(
    .DEPTH (VALUE_DEPTH),
    .AW    (AW)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(cnt_q)),
    .wdata_i (body_byte_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ufe_emitter #(
    .CNT_W (CNT_W),
    .AW    (AW)
  ) u_emitter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (emit_req),
    .n_i            (emit_n),
    .busy_o         (emit_busy),
    .raddr_o        (ram_raddr),
    .rdata_i        (ram_rdata),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .value_byte_o   (value_byte_o),
    .byte_present_o (byte_present_o),
    .status_o       (status_o),
    .final_result_o (final_result_o)
  );

  assign in_stall_o = emit_busy;

`ifndef SYNTHESIS
  a_end_restarts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && body_done |=> phase_q == ufe_pkg::PH_MATCH && pos_q == '0)
    else $error("scan did not restart after end of body");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_req.start |-> !emit_busy)
    else $error("emission requested while decoder busy");

  a_error_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ufe_pkg::STATUS_OK |-> final_result_o && !byte_present_o)
    else $error("error status on a non-final transaction");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    8'(cnt_q) <= 8'(LIM_MAX + 1))
    else $error("value count past saturation");
`endif

endmodule

>>> test/tb_form_pkg.sv
`timescale 1ns / 1ps
// Predicts the form field extractor's results and checks them as they come out.
package tb_form_pkg;

  localparam int VALUE_DEPTH      = 64;
  localparam int KEY_MAX          = 8;
  localparam int SHOWN_MISMATCHES = 10;

  class extracted_value_checker;
    logic [63:0]          key_chars;
    logic [3:0]           key_len;
    logic [6:0]           max_len;
    ufe_pkg::scan_phase_e phase;
    int unsigned          pair_pos;
    int unsigned          value_cnt;
    logic [7:0]           value_buf [VALUE_DEPTH];
    ufe_pkg::result_t     pending_values [$];
    int unsigned bytes_taken, bodies_ended, failures;
    int unsigned decoded_bytes, empty_values, not_found_seen, too_long_seen;

    function new();
      key_chars = '0;
      key_len   = 4'd1;
      max_len   = 7'd32;
      phase     = ufe_pkg::PH_MATCH;
      pair_pos  = 0;
      value_cnt = 0;
    endfunction

    function void set_register(ufe_pkg::reg_index_e idx, logic [63:0] data);
      case (idx)
        ufe_pkg::REG_KEY_BYTES: key_chars = data;
        ufe_pkg::REG_KEY_LENGTH: key_len = data[3:0];
        ufe_pkg::REG_MAX_VALUE_LENGTH: max_len = data[6:0];
        default: begin
        end
      endcase
    endfunction

    function int unsigned value_limit();
      return (max_len > VALUE_DEPTH) ? VALUE_DEPTH : max_len;
    endfunction

    function int hex_nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function void push_result(logic [7:0] data, logic present, ufe_pkg::status_e status,
                              logic last);
      ufe_pkg::result_t r;
      r.data    = data;
      r.present = present;
      r.status  = status;
      r.last    = last;
      pending_values.push_back(r);
    endfunction

    // Decodes the buffered raw value into one result per output byte, or one status-only result if empty or too long.
    function void decode_stored_value();
      int unsigned idx;
      int hi, lo;
      logic [7:0] c;
      idx = 0;
      if (value_cnt > value_limit()) begin
        push_result(8'h00, 1'b0, ufe_pkg::STATUS_TOO_LONG, 1'b1);
        return;
      end
      if (value_cnt == 0) begin
        push_result(8'h00, 1'b0, ufe_pkg::STATUS_OK, 1'b1);
        return;
      end
      while (idx < value_cnt) begin
        c = value_buf[idx];
        idx++;
        if (c == ufe_pkg::CHAR_PLUS) begin
          c = ufe_pkg::CHAR_SPACE;
        end else if (c == ufe_pkg::CHAR_PCT && idx + 1 < value_cnt) begin
          hi = hex_nibble(value_buf[idx]);
          lo = hex_nibble(value_buf[idx + 1]);
          if (hi >= 0 && lo >= 0) begin
            c = {hi[3:0], lo[3:0]};
            idx += 2;
          end
        end
        push_result(c, 1'b1, ufe_pkg::STATUS_OK, idx >= value_cnt);
      end
    endfunction

    function void note_body_byte(logic [7:0] b, logic last_byte);
      int unsigned klen;
      logic ended;
      klen  = (key_len > KEY_MAX) ? KEY_MAX : key_len;
      ended = last_byte || (b == ufe_pkg::CHAR_NUL);
      bytes_taken++;
      if (b != ufe_pkg::CHAR_NUL) begin
        case (phase)
          ufe_pkg::PH_MATCH: begin
            if (b == ufe_pkg::CHAR_AMP) begin
              pair_pos = 0;
            end else if (pair_pos < klen) begin
              if (b == key_chars[8*pair_pos +: 8]) pair_pos++;
              else phase = ufe_pkg::PH_SKIP;
            end else if (b == ufe_pkg::CHAR_EQ) begin
              phase     = ufe_pkg::PH_VALUE;
              value_cnt = 0;
            end else begin
              phase = ufe_pkg::PH_SKIP;
            end
          end
          ufe_pkg::PH_VALUE: begin
            if (b == ufe_pkg::CHAR_AMP) begin
              phase = ufe_pkg::PH_DONE;
              decode_stored_value();
            end else begin
              if (value_cnt < VALUE_DEPTH) value_buf[value_cnt] = b;
              if (value_cnt <= value_limit()) value_cnt++;
            end
          end
          ufe_pkg::PH_SKIP: begin
            if (b == ufe_pkg::CHAR_AMP) begin
              phase    = ufe_pkg::PH_MATCH;
              pair_pos = 0;
            end
          end
          default: begin
          end
        endcase
      end
      if (ended) begin
        if (phase == ufe_pkg::PH_VALUE) decode_stored_value();
        else if (phase != ufe_pkg::PH_DONE) begin
          push_result(8'h00, 1'b0, ufe_pkg::STATUS_NOT_FOUND, 1'b1);
        end
        phase     = ufe_pkg::PH_MATCH;
        pair_pos  = 0;
        value_cnt = 0;
        bodies_ended++;
      end
    endfunction

    function void check_value_result(logic [7:0] data, logic present, logic [1:0] status,
                                     logic last);
      ufe_pkg::result_t want;
      if (pending_values.size() == 0) begin
        failures++;
        if (failures <= SHOWN_MISMATCHES) begin
          $display("Unexpected result: byte %02h present %0d status %0d final %0d",
                   data, present, status, last);
        end
        return;
      end
      want = pending_values.pop_front();
      if (data !== want.data || present !== want.present || status !== want.status ||
          last !== want.last) begin
        failures++;
        if (failures <= SHOWN_MISMATCHES) begin
          $display("Mismatch: expected byte %02h present %0d status %0d final %0d",
                   want.data, want.present, want.status, want.last);
          $display("          got      byte %02h present %0d status %0d final %0d",
                   data, present, status, last);
        end
      end
      case (want.status)
        ufe_pkg::STATUS_NOT_FOUND: not_found_seen++;
        ufe_pkg::STATUS_TOO_LONG: too_long_seen++;
        default: begin
          if (want.present) decoded_bytes++;
          else empty_values++;
        end
      endcase
    endfunction
  endclass

endpackage

>>> test/tb_urlencoded_form_field_extract.sv
`timescale 1ns / 1ps
// Top-level testbench of the form field extractor: stimulus, handshakes and the final verdict.
module tb_urlencoded_form_field_extract;

  localparam int PHASE_BUDGET  = 20;
  localparam int HOLD_CYCLES   = 250;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } body_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  body_byte_i;
  logic        body_end_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  value_byte_o;
  logic        byte_present_o;
  logic [1:0]  status_o;
  logic        final_result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  tb_form_pkg::extracted_value_checker sb;
  body_item_t  body_queue [$];
  logic [63:0] cur_key;
  int unsigned cur_klen;
  int unsigned cur_limit;
  int unsigned settings_used;
  int unsigned hold_reqs;
  bit          calm;

  urlencoded_form_field_extract u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_urlencoded_form_field_extract: done, errors");
    $finish;
  end

  initial begin : rx_side
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_reqs) begin
        holds_served = hold_reqs;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 9);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_body_byte(body_byte_i, body_end_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_value_result(value_byte_o, byte_present_o, status_o, final_result_o);
      end
    end
  end

  function automatic void add_byte(logic [7:0] b, logic e);
    body_item_t it;
    it.data = b;
    it.last = e;
    body_queue.push_back(it);
  endfunction

  function automatic void add_text(string s, bit end_last);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], end_last && (i == s.len() - 1));
  endfunction

  function automatic void add_key(int unsigned n);
    for (int i = 0; i < n; i++) add_byte(cur_key[8*i +: 8], 1'b0);
  endfunction

  function automatic int pick_len();
    case ($urandom_range(9))
      6: return cur_limit;
      7: return cur_limit + 1;
      8: return $urandom_range(cur_limit + 3);
      9: return ($urandom_range(3) == 0) ? $urandom_range(cur_limit, 70) : cur_limit + 2;
      default: return $urandom_range(6);
    endcase
  endfunction

  function automatic void add_value(int len);
    string hexes = "0123456789abcdefABCDEFgG";
    int k;
    int r;
    logic [7:0] c;
    k = 0;
    while (k < len) begin
      r = $urandom_range(9);
      if (r < 2) c = ufe_pkg::CHAR_PLUS;
      else if (r < 4) c = ufe_pkg::CHAR_PCT;
      else if (r < 7) c = hexes[$urandom_range(hexes.len() - 1)];
      else if (r == 7) c = 8'($urandom_range(97, 122));
      else begin
        c = 8'($urandom_range(1, 255));
        if (c == ufe_pkg::CHAR_AMP) c = ufe_pkg::CHAR_EQ;
      end
      add_byte(c, 1'b0);
      k++;
      if (c == ufe_pkg::CHAR_PCT && $urandom_range(9) < 7) begin
        for (int d = 0; d < 2 && k < len; d++) begin
          add_byte(hexes[$urandom_range(hexes.len() - 1)], 1'b0);
          k++;
        end
      end
    end
  endfunction

  function automatic void add_pair();
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        add_key(cur_klen);
        add_byte(ufe_pkg::CHAR_EQ, 1'b0);
        add_value(pick_len());
      end
      4: begin
        add_key($urandom_range(cur_klen));
        add_byte(8'($urandom_range(97, 122)), 1'b0);
        add_byte(ufe_pkg::CHAR_EQ, 1'b0);
        add_value($urandom_range(4));
      end
      5: begin
        add_key(cur_klen);
        add_byte(8'($urandom_range(97, 122)), 1'b0);
        add_value($urandom_range(4));
      end
      6: begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(97, 122)), 1'b0);
        add_byte(ufe_pkg::CHAR_EQ, 1'b0);
        add_value($urandom_range(4));
      end
      7: begin
      end
      8: repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(1, 255)), 1'b0);
      default: begin
        add_key(cur_klen);
        add_byte(ufe_pkg::CHAR_EQ, 1'b0);
      end
    endcase
  endfunction

  function automatic void add_body();
    int unsigned start;
    int unsigned pairs;
    body_item_t it;
    start = body_queue.size();
    pairs = $urandom_range(1, 4);
    for (int p = 0; p < pairs; p++) begin
      if (p != 0) add_byte(ufe_pkg::CHAR_AMP, 1'b0);
      add_pair();
    end
    if (body_queue.size() > start && body_queue[$].data != ufe_pkg::CHAR_NUL &&
        $urandom_range(9) < 6) begin
      it = body_queue.pop_back();
      it.last = 1'b1;
      body_queue.push_back(it);
    end else begin
      add_byte(ufe_pkg::CHAR_NUL, 1'($urandom_range(1)));
    end
  endfunction

  task automatic write_reg(ufe_pkg::reg_index_e idx, logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, data);
  endtask

  task automatic apply_settings(logic [63:0] key, logic [3:0] klen, logic [6:0] mlen);
    write_reg(ufe_pkg::REG_KEY_BYTES, key);
    write_reg(ufe_pkg::REG_KEY_LENGTH, 64'(klen));
    write_reg(ufe_pkg::REG_MAX_VALUE_LENGTH, 64'(mlen));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_key   = key;
    cur_klen  = (klen > tb_form_pkg::KEY_MAX) ? tb_form_pkg::KEY_MAX : klen;
    cur_limit = (mlen > tb_form_pkg::VALUE_DEPTH) ? tb_form_pkg::VALUE_DEPTH : mlen;
    settings_used++;
  endtask

  task automatic play_bodies();
    body_item_t it;
    while (body_queue.size() != 0) begin
      it = body_queue.pop_front();
      if (!calm && $urandom_range(99) < 4) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      body_byte_i <= it.data;
      body_end_i  <= it.last;
      do @(posedge clk_i); while (in_stall_o);
    end
    in_valid_i <= 1'b0;
  endtask

  // A body may end in a state that gives no result, so the wait also idles after the expected results are in.
  task automatic wait_drained();
    while (sb.pending_values.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] key;
    sb = new();
    calm          = 1'b0;
    hold_reqs     = 0;
    settings_used = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    body_byte_i <= 8'h00;
    body_end_i  <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_settings(64'h6B, 4'd1, 7'd8);
    add_text("k=+%41%4g%", 1'b1);
    add_text("k=", 1'b0);
    add_byte(ufe_pkg::CHAR_NUL, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_text("&k", 1'b1);
    add_text("k=&k=q", 1'b1);
    hold_reqs++;
    play_bodies();
    wait_drained();

    apply_settings(64'h6B, 4'd1, 7'd0);
    add_text("k=1", 1'b1);
    add_byte(ufe_pkg::CHAR_NUL, 1'b1);
    play_bodies();
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 8; i++) key[8*i +: 8] = 8'($urandom_range(97, 122));
      case (ph)
        0: apply_settings(key, 4'd3, 7'd16);
        1: apply_settings(key, 4'd0, 7'd8);
        2: apply_settings(key, 4'd8, 7'd64);
        3: apply_settings(key, 4'd12, 7'd127);
        4: apply_settings(key, 4'd1, 7'd0);
        5: apply_settings('1, 4'd2, 7'd5);
        6: begin
          key[15:8]  = ufe_pkg::CHAR_AMP;
          key[23:16] = ufe_pkg::CHAR_NUL;
          apply_settings(key, 4'd3, 7'd10);
        end
        default: apply_settings({$urandom, $urandom}, 4'd15, 7'($urandom_range(1, 127)));
      endcase
      calm = (ph == 2);
      while (body_queue.size() < PHASE_BUDGET) add_body();
      play_bodies();
      wait_drained();
    end
    calm = 1'b0;

    $display("Run covered %0d body bytes in %0d bodies over %0d register settings.",
             sb.bytes_taken, sb.bodies_ended, settings_used);
    $display("Results: %0d decoded bytes, %0d empty values, %0d not found, %0d too long.",
             sb.decoded_bytes, sb.empty_values, sb.not_found_seen, sb.too_long_seen);
    if (sb.failures == 0 && sb.pending_values.size() == 0) begin
      $display("tb_urlencoded_form_field_extract: done, clean");
    end else begin
      $display("tb_urlencoded_form_field_extract: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ufe_pkg.sv
rtl/ufe_cfg_regs.sv
rtl/ufe_value_ram.sv
rtl/ufe_emitter.sv
rtl/urlencoded_form_field_extract.sv
test/tb_form_pkg.sv
test/tb_urlencoded_form_field_extract.sv
